// File: rtl/ffma_pkg.sv
// shared types and constants for the foot-force moving average
`default_nettype none
package ffma_pkg;

   // samples per leg in the averaging window (power of two)
   localparam int WINDOW   = 8;
   localparam int LEGS     = 4;
   localparam int WIN_BITS = $clog2(WINDOW);

   localparam int RAW_W  = 16;
   localparam int SUM_W  = RAW_W + WIN_BITS;
   localparam int OUT_W  = 20;
   localparam int EXT_W  = RAW_W + WIN_BITS + 1;
   localparam int SAT_W  = (EXT_W > OUT_W) ? EXT_W : OUT_W + 1;
   localparam int CSR_W  = 16;
   localparam int CSR_IDX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_FL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_FR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_RL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_RR = 3'd3;

   // leg numbering used inside the block
   localparam int LEG_FL = 0;
   localparam int LEG_FR = 1;
   localparam int LEG_RL = 2;
   localparam int LEG_RR = 3;

   localparam logic signed [RAW_W-1:0] OFFSET_RESET_FL = 16'sd3;
   localparam logic signed [RAW_W-1:0] OFFSET_RESET_FR = 16'sd22;
   localparam logic signed [RAW_W-1:0] OFFSET_RESET_RL = 16'sd92;
   localparam logic signed [RAW_W-1:0] OFFSET_RESET_RR = 16'sd72;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_fr;
      logic signed [RAW_W-1:0] raw_fl;
      logic signed [RAW_W-1:0] raw_rr;
      logic signed [RAW_W-1:0] raw_rl;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] filtered_fl;
      logic signed [OUT_W-1:0] filtered_fr;
      logic signed [OUT_W-1:0] filtered_rl;
      logic signed [OUT_W-1:0] filtered_rr;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/ffma_leg.sv
// one leg: sample ring, running sum and offset-corrected saturated result
`default_nettype none
module ffma_leg (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic [ffma_pkg::WIN_BITS-1:0]       pos,
   input  wire logic signed [ffma_pkg::RAW_W-1:0]   sample,
   input  wire logic signed [ffma_pkg::RAW_W-1:0]   offset,
   output logic signed [ffma_pkg::OUT_W-1:0]        filtered
);
   import ffma_pkg::*;

   localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0] OUT_MIN = -SAT_W'(1 << (OUT_W - 1));

   logic signed [RAW_W-1:0] ring_ff [WINDOW];
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [RAW_W-1:0] oldest;
   logic signed [SAT_W-1:0] diff;

   assign oldest = ring_ff[pos];
   assign sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (advance) begin
         sum_ff       <= sum_in;
         ring_ff[pos] <= sample;
      end
   end

   // result for the request being accepted, from the updated sum
   always_comb begin
      diff = SAT_W'(sum_in) - (SAT_W'(offset) <<< WIN_BITS);
      if (diff > OUT_MAX) begin
         filtered = OUT_MAX[OUT_W-1:0];
      end else if (diff < OUT_MIN) begin
         filtered = OUT_MIN[OUT_W-1:0];
      end else begin
         filtered = diff[OUT_W-1:0];
      end
   end

endmodule
`default_nettype wire

// File: rtl/foot_force_moving_average.sv
// a request accepted at one edge is registered in rsp_data_ff at that edge and shows at rsp_data right after it
// throughput: one request per cycle while req_stall is low; the four leg rings update in parallel in the accept cycle
// the input is stalled only while a finished result is held by rsp_stall
// reset (synchronous, active high) clears all sample rings, sums and the ring position,
// and loads the offsets with their defaults
`default_nettype none
module foot_force_moving_average (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire ffma_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output ffma_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [ffma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ffma_pkg::CSR_W-1:0]        csr_wdata
);
   import ffma_pkg::*;

   logic                    accept;
   logic [WIN_BITS-1:0]     pos_ff;
   logic [WIN_BITS-1:0]     pos_in;
   logic signed [RAW_W-1:0] offset_ff [LEGS];
   logic signed [RAW_W-1:0] sample [LEGS];
   logic signed [OUT_W-1:0] filtered [LEGS];
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // hardware slot order to leg order
   assign sample[LEG_FL] = req_data.raw_fl;
   assign sample[LEG_FR] = req_data.raw_fr;
   assign sample[LEG_RL] = req_data.raw_rl;
   assign sample[LEG_RR] = req_data.raw_rr;

   assign pos_in = (pos_ff == WIN_BITS'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;

   for (genvar g = 0; g < LEGS; g++) begin : g_leg
      ffma_leg u_leg (
         .clock    (clock),
         .reset    (reset),
         .advance  (accept),
         .pos      (pos_ff),
         .sample   (sample[g]),
         .offset   (offset_ff[g]),
         .filtered (filtered[g])
      );
   end

   always_comb begin
      rsp_data_in.filtered_fl = filtered[LEG_FL];
      rsp_data_in.filtered_fr = filtered[LEG_FR];
      rsp_data_in.filtered_rl = filtered[LEG_RL];
      rsp_data_in.filtered_rr = filtered[LEG_RR];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // offsets; writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff[LEG_FL] <= OFFSET_RESET_FL;
         offset_ff[LEG_FR] <= OFFSET_RESET_FR;
         offset_ff[LEG_RL] <= OFFSET_RESET_RL;
         offset_ff[LEG_RR] <= OFFSET_RESET_RR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_FL: offset_ff[LEG_FL] <= csr_wdata[RAW_W-1:0];
            CSR_OFFSET_FR: offset_ff[LEG_FR] <= csr_wdata[RAW_W-1:0];
            CSR_OFFSET_RL: offset_ff[LEG_RL] <= csr_wdata[RAW_W-1:0];
            CSR_OFFSET_RR: offset_ff[LEG_RR] <= csr_wdata[RAW_W-1:0];
            default: ;
         endcase
      end
   end

   // input only backs up behind a held result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no result");

   a_pos_advances: assert property (@(posedge clock) disable iff (reset)
      accept |=> pos_ff == $past(pos_in))
      else $error("ring position did not advance on accept");

   a_pos_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(pos_ff))
      else $error("ring position moved without a request");

endmodule
`default_nettype wire
